// ===== sv/lcs_pkg.sv =====
// shared constants and command codes for the lcs length engine
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

    // default sizes
    localparam int MAX_LEN_DEF   = 64;
    localparam int CHAR_BITS_DEF = 8;

    // fixed port widths
    localparam int CMD_W     = 2;
    localparam int CH_W      = 8;
    localparam int LEN_OUT_W = 7;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_FIRST  = 2'd0,
        CMD_LOAD_SECOND = 2'd1,
        CMD_COMPUTE     = 2'd2
    } cmd_t;

endpackage

`default_nettype wire

// ===== sv/longest_common_subsequence_length.sv =====
// Loads are taken in the idle state and never produce an item.
// A compute walks the dp table row by row, then registers its result item in the done
// state (entered at once if either string is empty), waiting there while output stalls;
// input stalls until then, and the next item can be taken in the following cycle.
// The dp cell unit is shared; per cell a ram read then a write state, per row a fetch state.
// Reset clears lengths, overflow flag and control; string and row rams need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module longest_common_subsequence_length #(
    parameter int MAX_LEN   = lcs_pkg::MAX_LEN_DEF,
    parameter int CHAR_BITS = lcs_pkg::CHAR_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [lcs_pkg::CMD_W-1:0]     cmd,
    input  wire logic [lcs_pkg::CH_W-1:0]      ch,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [lcs_pkg::LEN_OUT_W-1:0] lcs_length,
    output logic                               overflow
);

    import lcs_pkg::*;

    localparam int SW = (CHAR_BITS < CH_W) ? CHAR_BITS : CH_W;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_READ,
        ST_CALC,
        ST_DONE
    } state_t;

    state_t          state_reg;
    logic [LW-1:0]   first_len_reg;
    logic [LW-1:0]   second_len_reg;
    logic            overflow_reg;
    logic [LW-1:0]   i_reg;
    logic [LW-1:0]   j_reg;
    logic [LW-1:0]   left_reg;
    logic [LW-1:0]   diag_reg;
    logic            out_valid_reg;
    logic [LW-1:0]   lcs_length_reg;
    logic            overflow_out_reg;

    logic            in_accept;
    logic            out_free;
    logic [SW-1:0]   ch_bits;
    logic            first_we;
    logic            second_we;
    logic            first_rd_en;
    logic            second_rd_en;
    logic            row_we;
    logic [SW-1:0]   first_rd_data;
    logic [SW-1:0]   second_rd_data;
    logic [LW-1:0]   row_rd_data;
    logic [LW-1:0]   up_value;
    logic [LW-1:0]   cell_value;
    logic            last_col;
    logic            last_row;

    // handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign ch_bits   = ch[SW-1:0];

    // string loads and ram read strobes
    assign first_we     = in_accept && (cmd == CMD_LOAD_FIRST)
                          && (first_len_reg < LW'(MAX_LEN));
    assign second_we    = in_accept && (cmd == CMD_LOAD_SECOND)
                          && (second_len_reg < LW'(MAX_LEN));
    assign first_rd_en  = (state_reg == ST_ROW);
    assign second_rd_en = (state_reg == ST_READ);
    assign row_we       = (state_reg == ST_CALC);

    // first row sees a zero row above it
    assign up_value = (i_reg == '0) ? '0 : row_rd_data;
    assign last_col = (j_reg == LW'(second_len_reg - 1'b1));
    assign last_row = (i_reg == LW'(first_len_reg - 1'b1));

    lcs_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_LEN)
    ) u_first_ram (
        .clk     (clk),
        .we      (first_we),
        .wr_addr (first_len_reg[AW-1:0]),
        .wr_data (ch_bits),
        .rd_en   (first_rd_en),
        .rd_addr (i_reg[AW-1:0]),
        .rd_data (first_rd_data)
    );

    lcs_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_LEN)
    ) u_second_ram (
        .clk     (clk),
        .we      (second_we),
        .wr_addr (second_len_reg[AW-1:0]),
        .wr_data (ch_bits),
        .rd_en   (second_rd_en),
        .rd_addr (j_reg[AW-1:0]),
        .rd_data (second_rd_data)
    );

    // entry j holds dp row column j+1
    lcs_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_LEN)
    ) u_row_ram (
        .clk     (clk),
        .we      (row_we),
        .wr_addr (j_reg[AW-1:0]),
        .wr_data (cell_value),
        .rd_en   (second_rd_en),
        .rd_addr (j_reg[AW-1:0]),
        .rd_data (row_rd_data)
    );

    lcs_cell #(
        .SW (SW),
        .LW (LW)
    ) u_cell (
        .char_a     (first_rd_data),
        .char_b     (second_rd_data),
        .diag       (diag_reg),
        .up         (up_value),
        .left       (left_reg),
        .cell_value (cell_value)
    );

    // sequencer, loads and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            first_len_reg    <= '0;
            second_len_reg   <= '0;
            overflow_reg     <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            left_reg         <= '0;
            diag_reg         <= '0;
            out_valid_reg    <= 1'b0;
            lcs_length_reg   <= '0;
            overflow_out_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        case (cmd)
                            CMD_LOAD_FIRST:
                            begin
                                if (first_we)
                                begin
                                    first_len_reg <= LW'(first_len_reg + 1'b1);
                                end
                                else
                                begin
                                    overflow_reg <= 1'b1;
                                end
                            end
                            CMD_LOAD_SECOND:
                            begin
                                if (second_we)
                                begin
                                    second_len_reg <= LW'(second_len_reg + 1'b1);
                                end
                                else
                                begin
                                    overflow_reg <= 1'b1;
                                end
                            end
                            CMD_COMPUTE:
                            begin
                                i_reg    <= '0;
                                left_reg <= '0;
                                if ((first_len_reg == '0) || (second_len_reg == '0))
                                begin
                                    state_reg <= ST_DONE;
                                end
                                else
                                begin
                                    state_reg <= ST_ROW;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                // fetch first string character for this row
                ST_ROW:
                begin
                    j_reg     <= '0;
                    left_reg  <= '0;
                    diag_reg  <= '0;
                    state_reg <= ST_READ;
                end

                // ram reads for one cell are issued here
                ST_READ:
                begin
                    state_reg <= ST_CALC;
                end

                // evaluate one cell and write it back
                ST_CALC:
                begin
                    left_reg <= cell_value;
                    diag_reg <= up_value;
                    if (!last_col)
                    begin
                        j_reg     <= LW'(j_reg + 1'b1);
                        state_reg <= ST_READ;
                    end
                    else if (!last_row)
                    begin
                        i_reg     <= LW'(i_reg + 1'b1);
                        state_reg <= ST_ROW;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end

                // hand over the result once the output slot is free
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        lcs_length_reg   <= left_reg;
                        overflow_out_reg <= overflow_reg;
                        first_len_reg    <= '0;
                        second_len_reg   <= '0;
                        overflow_reg     <= 1'b0;
                        state_reg        <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign lcs_length = LEN_OUT_W'(lcs_length_reg);
    assign overflow   = overflow_out_reg;

endmodule

`default_nettype wire

// ===== sv/lcs_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/lcs_cell.sv =====
// shared dp cell unit: character compare, diagonal increment, max of up and left
`timescale 1ns / 1ps
`default_nettype none

module lcs_cell #(
    parameter int SW = 8,
    parameter int LW = 7
) (
    input  wire logic [SW-1:0] char_a,
    input  wire logic [SW-1:0] char_b,
    input  wire logic [LW-1:0] diag,
    input  wire logic [LW-1:0] up,
    input  wire logic [LW-1:0] left,
    output logic      [LW-1:0] cell_value
);

    // match takes diagonal plus one, otherwise the larger neighbour
    always_comb
    begin
        if (char_a == char_b)
        begin
            cell_value = LW'(diag + 1'b1);
        end
        else if (up > left)
        begin
            cell_value = up;
        end
        else
        begin
            cell_value = left;
        end
    end

endmodule

`default_nettype wire
